[sv/atd_pkg.sv]
// atd_pkg: shared constants, types and pattern tables for the terminator detector
// no dependencies

package atd_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CMP_W     = (IDX_W > 8) ? IDX_W : 8;
    localparam int HDR_COUNT = 2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] ERR_LAST = 3'd4;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_REARM = 2'd1,
        OP_READ  = 2'd2,
        OP_IDLE  = 2'd3
    } t_op;

    typedef struct packed {
        logic       fire;
        logic       take;
        logic       rearm;
        logic       rd_req;
        logic       overrun;
        logic [7:0] data;
        logic [7:0] rd_idx;
    } t_evt;

    typedef struct packed {
        logic [1:0]           status;
        logic [HDR_COUNT-1:0] msg_seen;
    } t_match;

    function automatic logic [7:0] ok_char(input logic pos);
        return pos ? "K" : "O";
    endfunction

    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "E";
            3'd3:    c = "O";
            default: c = "R";
        endcase
        return c;
    endfunction

    function automatic logic [3:0] hdr_len(input logic k);
        return k ? 4'd8 : 4'd9;
    endfunction

    function automatic logic [7:0] hdr_char(input logic k, input logic [3:0] pos);
        logic [7:0] c;
        case ({k, pos})
            5'h00:   c = "+";
            5'h01:   c = "U";
            5'h02:   c = "U";
            5'h03:   c = "S";
            5'h04:   c = "O";
            5'h05:   c = "R";
            5'h06:   c = "F";
            5'h07:   c = ":";
            5'h08:   c = " ";
            5'h10:   c = "+";
            5'h11:   c = "C";
            5'h12:   c = "R";
            5'h13:   c = "T";
            5'h14:   c = "D";
            5'h15:   c = "C";
            5'h16:   c = "P";
            5'h17:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[sv/atd_match.sv]
// atd_match: OK / ERROR terminator and unsolicited header matchers with status
// depends on atd_pkg

module atd_match (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  atd_pkg::t_evt i_evt,
    input  logic          i_cr_before,
    output logic          o_lock_set,
    output atd_pkg::t_match o_match
);
    import atd_pkg::*;

    logic                       r_ok, n_ok;
    logic [2:0]                 r_err, n_err;
    logic [HDR_COUNT-1:0][3:0]  r_hpos, n_hpos;
    logic [HDR_COUNT-1:0]       r_hseen, n_hseen;
    logic [HDR_COUNT-1:0]       r_msg, n_msg;
    logic [1:0]                 r_status, n_status;

    always_comb begin
        n_ok       = r_ok;
        n_err      = r_err;
        n_hpos     = r_hpos;
        n_hseen    = r_hseen;
        n_msg      = r_msg;
        n_status   = r_status;
        o_lock_set = 1'b0;
        if (i_evt.rearm) begin
            n_status = ST_NONE;
            n_hpos   = '0;
            n_hseen  = '0;
            n_msg    = '0;
        end else if (i_evt.take) begin
            if (i_evt.overrun) begin
                n_ok   = 1'b0;
                n_err  = '0;
                n_hpos = '0;
            end
            if (i_evt.data != 8'h00) begin
                for (int k = 0; k < HDR_COUNT; k++) begin
                    if (!r_msg[k]) begin
                        if (!r_hseen[k]) begin
                            if (i_evt.data == hdr_char(1'(k), n_hpos[k])) begin
                                if (n_hpos[k] == hdr_len(1'(k)) - 4'd1) begin
                                    n_hpos[k]  = '0;
                                    n_hseen[k] = 1'b1;
                                end else begin
                                    n_hpos[k] = n_hpos[k] + 4'd1;
                                end
                            end else begin
                                n_hpos[k] = '0;
                            end
                        end else if (i_evt.data == CH_LF && i_cr_before) begin
                            o_lock_set = 1'b1;
                            n_msg[k]   = 1'b1;
                            n_hseen[k] = 1'b0;
                            n_hpos[k]  = '0;
                        end
                    end
                end
                if (i_evt.data == ok_char(n_ok)) begin
                    if (n_ok) begin
                        o_lock_set = 1'b1;
                        n_ok       = 1'b0;
                        n_status   = ST_OK;
                    end else begin
                        n_ok = 1'b1;
                    end
                end else begin
                    n_ok = 1'b0;
                end
                if (i_evt.data == err_char(n_err)) begin
                    if (n_err == ERR_LAST) begin
                        o_lock_set = 1'b1;
                        n_err      = '0;
                        n_status   = ST_ERROR;
                    end else begin
                        n_err = n_err + 3'd1;
                    end
                end else begin
                    n_err = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok     <= 1'b0;
            r_err    <= '0;
            r_hpos   <= '0;
            r_hseen  <= '0;
            r_msg    <= '0;
            r_status <= ST_NONE;
        end else begin
            r_ok     <= n_ok;
            r_err    <= n_err;
            r_hpos   <= n_hpos;
            r_hseen  <= n_hseen;
            r_msg    <= n_msg;
            r_status <= n_status;
        end
    end

    assign o_match.status   = r_status;
    assign o_match.msg_seen = r_msg;

endmodule

[sv/atd_buffer.sv]
// atd_buffer: receive byte store, saturating write index and registered read port
// depends on atd_pkg

module atd_buffer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  atd_pkg::t_evt i_evt,
    output logic          o_cr_before,
    output logic [7:0]    o_count,
    output logic          o_overflow,
    output logic [7:0]    o_read_data
);
    import atd_pkg::*;

    logic [7:0]       r_mem [BUF_DEPTH];
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_ovf, n_ovf;
    logic             r_prev_cr, n_prev_cr;
    logic [7:0]       r_rd_data;

    logic [IDX_W-1:0] base;
    logic             at_top;
    logic             store;
    logic             rd_hit;
    logic [CMP_W-1:0] rd_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [IDX_W-1:0] rd_addr;

    assign base        = i_evt.overrun ? '0 : r_idx;
    assign at_top      = (base == IDX_W'(BUF_DEPTH - 1));
    assign store       = i_evt.take && (i_evt.data != 8'h00);
    assign o_cr_before = (base != '0) && r_prev_cr;

    assign rd_ext  = CMP_W'(i_evt.rd_idx);
    assign cnt_ext = CMP_W'(r_idx);
    assign rd_addr = rd_ext[IDX_W-1:0];
    assign rd_hit  = i_evt.rd_req && (rd_ext < cnt_ext);

    always_comb begin
        n_idx     = r_idx;
        n_ovf     = r_ovf;
        n_prev_cr = r_prev_cr;
        if (i_evt.rearm) begin
            n_idx = '0;
            n_ovf = 1'b0;
        end else if (i_evt.take) begin
            n_idx = base;
            if (store) begin
                if (at_top) begin
                    n_ovf = 1'b1;
                end else begin
                    n_idx     = base + IDX_W'(1);
                    n_prev_cr = (i_evt.data == CH_CR);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_prev_cr <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_ovf     <= n_ovf;
            r_prev_cr <= n_prev_cr;
        end
    end

    // store and read port
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[base] <= i_evt.data;
        end
        if (i_evt.fire) begin
            r_rd_data <= rd_hit ? r_mem[rd_addr] : 8'h00;
        end
    end

    assign o_count     = cnt_ext[7:0];
    assign o_overflow  = r_ovf;
    assign o_read_data = r_rd_data;

endmodule

[sv/at_response_terminator_detector.sv]
// at_response_terminator_detector: top level, input register, lock and lost flags
// depends on atd_pkg, atd_match, atd_buffer
//
//   channel | direction | handshake              | fields
//   in      | to block  | i_in_valid, o_in_stall | operation, rx_byte, uart_overrun, read_index
//   out     | from block| o_out_valid, i_out_stall | status, flags, stored_count, read_data
//
// one item per cycle sustained while the output is not stalled; registered in the input register, then in the result
// the result fields are the state registers and the registered buffer read
// synchronous active-low reset clears all flags and indices; buffer contents stay undefined
// a stalled result holds; the input stalls only while both the input register and the
// result are full and the output is stalled

module at_response_terminator_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_rx_byte,
    input  logic       i_uart_overrun,
    input  logic [7:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_response_status,
    output logic       o_buffer_locked,
    output logic       o_buffer_overflow,
    output logic       o_bytes_lost,
    output logic [7:0] o_stored_count,
    output logic       o_udp_message_seen,
    output logic       o_nidd_message_seen,
    output logic [7:0] o_read_data
);
    import atd_pkg::*;

    logic       r_s1_valid, n_s1_valid;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_op;
    logic [7:0] r_data;
    logic       r_ovr;
    logic [7:0] r_ridx;
    logic       r_locked, n_locked;
    logic       r_lost, n_lost;

    logic   adv;
    logic   fire;
    logic   in_acc;
    t_op    op;
    t_evt   evt;
    t_match match;
    logic   lock_set;
    logic   cr_before;
    logic   is_delim;

    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && adv;
    assign o_in_stall = r_s1_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign op         = t_op'(r_op);
    assign is_delim   = (r_data == CH_CR) || (r_data == CH_LF) || (r_data == CH_SP);

    assign evt.fire    = fire;
    assign evt.take    = fire && (op == OP_BYTE) && !r_locked;
    assign evt.rearm   = fire && (op == OP_REARM);
    assign evt.rd_req  = fire && (op == OP_READ);
    assign evt.overrun = r_ovr;
    assign evt.data    = r_data;
    assign evt.rd_idx  = r_ridx;

    atd_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_cr_before (cr_before),
        .o_lock_set  (lock_set),
        .o_match     (match)
    );

    atd_buffer u_buffer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .o_cr_before (cr_before),
        .o_count     (o_stored_count),
        .o_overflow  (o_buffer_overflow),
        .o_read_data (o_read_data)
    );

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        n_locked    = r_locked;
        n_lost      = r_lost;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (fire) begin
            n_s1_valid = 1'b0;
        end
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (evt.rearm) begin
            n_locked = 1'b0;
            n_lost   = 1'b0;
        end else begin
            if (lock_set) begin
                n_locked = 1'b1;
            end
            if (fire && (op == OP_BYTE) && r_locked && !is_delim) begin
                n_lost = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_locked    <= 1'b0;
            r_lost      <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_locked    <= n_locked;
            r_lost      <= n_lost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_operation;
            r_data <= i_rx_byte;
            r_ovr  <= i_uart_overrun;
            r_ridx <= i_read_index;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_response_status   = match.status;
    assign o_buffer_locked     = r_locked;
    assign o_bytes_lost        = r_lost;
    assign o_udp_message_seen  = match.msg_seen[0];
    assign o_nidd_message_seen = match.msg_seen[1];

    // a terminator status always comes with the lock
    a_status_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (match.status != ST_NONE) |-> r_locked)
        else $error("status set without lock");

    // a completed message always comes with the lock
    a_msg_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (match.msg_seen != '0) |-> r_locked)
        else $error("message seen without lock");

    // only a rearm releases the lock
    a_unlock_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_locked)) |-> $past(evt.rearm))
        else $error("lock released without rearm");

    // lost flag rises only on an item fired while locked
    a_lost_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_lost)) |-> ($past(r_locked) && $past(fire)))
        else $error("lost flag set while unlocked");

endmodule
